### hdl/ffha_pkg.sv
// types and constants shared by the first-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int GRANULE_BYTES = 8;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_FREE = 2'd1;
  localparam logic [1:0] K_USED = 2'd2;

  // granule index or size, and a free-list link whose top bit marks the end
  typedef logic [13:0] gran_t;
  typedef logic [14:0] lnk_t;
  localparam lnk_t NIL = 15'h4000;

  typedef struct packed {
    logic [1:0] kind;
    gran_t      size;
    lnk_t       next;
  } hdr_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] request_size;
    logic [15:0] pointer;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_pointer;
    logic [1:0]  status;
    logic [15:0] copy_bytes;
    logic [15:0] usable_bytes;
  } out_item_t;

endpackage

### hdl/first_fit_heap_allocator.sv
// first-fit heap allocator: sequencer, header memory and result register
// depends on ffha_pkg
`timescale 1ns / 1ps
//
// Usage: an item on in_item (op, request_size, pointer) is taken when in_valid
// is high and in_stall low; in_stall is high while an item is being worked on
// and during reset.
// One result item per input item appears on out_item under out_valid and
// leaves when out_stall is low. The result register lets the next item be
// taken while a finished result still waits.
// Configuration (heap_base index 0, heap_ceiling index 1) is written through
// cfg_we / cfg_index / cfg_data; the user must do so only while the block is
// idle, since the block itself does not enforce it. A query or a rejected
// pointer needs no list walk. An allocate walks the free list once, a free
// walks it once to insert, and a resize that moves walks it once to allocate
// and once to free. A heap extension first rounds its size up in EXTEND_BYTES
// steps (the first one also steps up to the padded heap start), then does a
// release walk and, for an allocate, a fresh allocate walk. The next item is
// taken in the cycle after its result is loaded. The pace is set by the
// single-port header memory, one access a cycle.
// Reset (rst_n low, synchronous) empties the free list and clears heap_end;
// the header memory is not cleared. A stalled result holds out_item and keeps
// the sequencer waiting in its last state until it is taken.
//
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES      = 65536,
  parameter int MIN_BLOCK_BYTES = 16,
  parameter int EXTEND_BYTES    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NGRAN = HEAP_BYTES / GRANULE_BYTES;
  localparam int AW = $clog2(NGRAN);
  localparam gran_t MIN_G = 14'(MIN_BLOCK_BYTES / GRANULE_BYTES);
  localparam logic [15:0] EXT_G = 16'(EXTEND_BYTES / GRANULE_BYTES);
  localparam logic [15:0] NGRAN_W = 16'(NGRAN);
  localparam logic [19:0] OOM_LIM = 20'(65535 - EXTEND_BYTES);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_VCHECK, S_ZAFTER, S_ZDECIDE, S_ZREREAD, S_ZWALK,
    S_ZSTEP, S_ZFOUND, S_ZABSORB, S_ZSETSZ, S_ZSHRINK, S_AMOVE,
    S_ASTART, S_AWALK, S_ACHECK, S_ATAKE, S_ALINK, S_ARET,
    S_ESTART, S_ERNDA, S_ERNDS, S_ECHK, S_ERET,
    S_RSTART, S_RWALK, S_RSTEP, S_RMERGE, S_RNEXT, S_RFIN, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    REL_FINISH, REL_ZOK, REL_EXT
  } rel_ret_t;

  // header memory
  hdr_t mem [NGRAN];
  logic  mem_we;
  gran_t mem_g;
  hdr_t  mem_wd;
  hdr_t  mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_g[AW-1:0]] <= mem_wd;
    end
    mem_q <= mem[mem_g[AW-1:0]];
  end

  state_t      state_r, state_nxt;
  in_item_t    item_r, item_nxt;
  gran_t       rg_r, rg_nxt;
  lnk_t        head_r, head_nxt;
  gran_t       heap_end_r, heap_end_nxt;
  logic        started_r, started_nxt;
  logic [15:0] base_r, ceil_r;
  lnk_t        prev_r, prev_nxt, cur_r, cur_nxt, cur_nx_r, cur_nx_nxt;
  lnk_t        link_r, link_nxt, bnext_r, bnext_nxt;
  gran_t       prev_sz_r, prev_sz_nxt, cur_sz_r, cur_sz_nxt;
  gran_t       blk_r, blk_nxt, bsz_r, bsz_nxt;
  gran_t       b_r, b_nxt, bsz2_r, bsz2_nxt, after_r, after_nxt, asz_r, asz_nxt;
  logic [1:0]  ak_r, ak_nxt;
  logic [15:0] amt_r, amt_nxt, acc_r, acc_nxt, ra_r, ra_nxt;
  logic [15:0] start_r, start_nxt, new_end_r, new_end_nxt;
  logic        ext_rsz_r, ext_rsz_nxt, alloc_mv_r, alloc_mv_nxt;
  logic        ext_ok_r, ext_ok_nxt, alloc_ok_r, alloc_ok_nxt;
  rel_ret_t    rel_ret_r, rel_ret_nxt;
  logic [15:0] res_r, res_nxt, copy_r, copy_nxt, usable_r, usable_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [16:0] rsum;
  gran_t       rg_raw, bg, need;
  logic        ptr_ok;
  gran_t       base_g;
  logic [16:0] base_sum;

  assign rsum     = {1'b0, in_item.request_size} + 17'd15;
  assign rg_raw   = rsum[16:3];
  assign bg       = {1'b0, item_r.pointer[15:3]} - 14'd1;
  assign ptr_ok   = (item_r.pointer >= 16'd8) && (item_r.pointer[2:0] == 3'd0) &&
                    started_r && (bg < heap_end_r);
  assign need     = rg_r - bsz2_r;
  assign base_sum = {1'b0, base_r} + 17'd7;
  assign base_g   = base_sum[16:3];

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    rg_nxt       = rg_r;
    head_nxt     = head_r;
    heap_end_nxt = heap_end_r;
    started_nxt  = started_r;
    prev_nxt     = prev_r;
    cur_nxt      = cur_r;
    cur_nx_nxt   = cur_nx_r;
    link_nxt     = link_r;
    bnext_nxt    = bnext_r;
    prev_sz_nxt  = prev_sz_r;
    cur_sz_nxt   = cur_sz_r;
    blk_nxt      = blk_r;
    bsz_nxt      = bsz_r;
    b_nxt        = b_r;
    bsz2_nxt     = bsz2_r;
    after_nxt    = after_r;
    asz_nxt      = asz_r;
    ak_nxt       = ak_r;
    amt_nxt      = amt_r;
    acc_nxt      = acc_r;
    ra_nxt       = ra_r;
    start_nxt    = start_r;
    new_end_nxt  = new_end_r;
    ext_rsz_nxt  = ext_rsz_r;
    alloc_mv_nxt = alloc_mv_r;
    ext_ok_nxt   = ext_ok_r;
    alloc_ok_nxt = alloc_ok_r;
    rel_ret_nxt  = rel_ret_r;
    res_nxt      = res_r;
    copy_nxt     = copy_r;
    usable_nxt   = usable_r;
    st_nxt       = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt = out_item_r;
    mem_we       = 1'b0;
    mem_g        = cur_r[13:0];
    mem_wd       = '{kind: K_NONE, size: '0, next: NIL};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_item;
          rg_nxt     = (rg_raw < MIN_G) ? MIN_G : rg_raw;
          res_nxt    = '0;
          copy_nxt   = '0;
          usable_nxt = '0;
          st_nxt     = ST_OK;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        b_nxt = bg;
        mem_g = bg;
        if (item_r.op == OP_ALLOC || (item_r.op == OP_RESIZE && item_r.pointer == 16'd0)) begin
          alloc_mv_nxt = 1'b0;
          state_nxt    = S_ASTART;
        end else if (item_r.pointer == 16'd0) begin
          state_nxt = S_FINISH;
        end else if (!ptr_ok) begin
          st_nxt    = ST_BAD;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_VCHECK;
        end
      end
      S_VCHECK: begin
        bsz2_nxt  = mem_q.size;
        after_nxt = b_r + mem_q.size;
        if (mem_q.kind != K_USED) begin
          st_nxt    = ST_BAD;
          state_nxt = S_FINISH;
        end else begin
          case (item_r.op)
            OP_FREE: begin
              blk_nxt     = b_r;
              bsz_nxt     = mem_q.size;
              rel_ret_nxt = REL_FINISH;
              state_nxt   = S_RSTART;
            end
            OP_QUERY: begin
              usable_nxt = 16'({mem_q.size, 3'b000} - 17'd8);
              state_nxt  = S_FINISH;
            end
            default: begin
              if (mem_q.size >= rg_r) begin
                state_nxt = S_ZSHRINK;
              end else begin
                mem_g = b_r + mem_q.size;
                if ((b_r + mem_q.size) < heap_end_r) begin
                  state_nxt = S_ZAFTER;
                end else begin
                  // block ends at the heap end: grow the heap first
                  ak_nxt      = K_NONE;
                  amt_nxt     = 16'({2'b00, b_r} + {2'b00, rg_r} - {2'b00, heap_end_r});
                  ext_rsz_nxt = 1'b1;
                  state_nxt   = S_ESTART;
                end
              end
            end
          endcase
        end
      end
      S_ZAFTER: begin
        ak_nxt  = mem_q.kind;
        asz_nxt = mem_q.size;
        if (mem_q.kind == K_FREE && mem_q.size < need &&
            ({1'b0, after_r} + {1'b0, mem_q.size}) == {1'b0, heap_end_r}) begin
          amt_nxt     = 16'({2'b00, b_r} + {2'b00, rg_r} - {2'b00, heap_end_r});
          ext_rsz_nxt = 1'b1;
          state_nxt   = S_ESTART;
        end else begin
          state_nxt = S_ZDECIDE;
        end
      end
      S_ZREREAD: begin
        ak_nxt    = mem_q.kind;
        asz_nxt   = mem_q.size;
        state_nxt = S_ZDECIDE;
      end
      S_ZDECIDE: begin
        if (ak_r == K_FREE && asz_r >= need) begin
          prev_nxt  = NIL;
          cur_nxt   = head_r;
          state_nxt = S_ZWALK;
        end else begin
          alloc_mv_nxt = 1'b1;
          state_nxt    = S_ASTART;
        end
      end
      S_ZWALK: begin
        mem_g = cur_r[13:0];
        if (cur_r == NIL) begin
          state_nxt = S_ZABSORB;
        end else if (cur_r == {1'b0, after_r}) begin
          state_nxt = S_ZFOUND;
        end else begin
          state_nxt = S_ZSTEP;
        end
      end
      S_ZSTEP: begin
        prev_nxt    = cur_r;
        prev_sz_nxt = mem_q.size;
        cur_nxt     = mem_q.next;
        state_nxt   = S_ZWALK;
      end
      S_ZFOUND: begin
        if (prev_r == NIL) begin
          head_nxt = mem_q.next;
        end else begin
          mem_we = 1'b1;
          mem_g  = prev_r[13:0];
          mem_wd = '{kind: K_FREE, size: prev_sz_r, next: mem_q.next};
        end
        state_nxt = S_ZABSORB;
      end
      S_ZABSORB: begin
        mem_we    = 1'b1;
        mem_g     = after_r;
        mem_wd    = '{kind: K_NONE, size: '0, next: NIL};
        bsz2_nxt  = bsz2_r + asz_r;
        state_nxt = S_ZSETSZ;
      end
      S_ZSETSZ: begin
        mem_we    = 1'b1;
        mem_g     = b_r;
        mem_wd    = '{kind: K_USED, size: bsz2_r, next: NIL};
        state_nxt = S_ZSHRINK;
      end
      S_ZSHRINK: begin
        if ((bsz2_r - rg_r) >= MIN_G) begin
          // give the excess back as a freed tail block
          mem_we      = 1'b1;
          mem_g       = b_r;
          mem_wd      = '{kind: K_USED, size: rg_r, next: NIL};
          blk_nxt     = b_r + rg_r;
          bsz_nxt     = bsz2_r - rg_r;
          rel_ret_nxt = REL_ZOK;
          state_nxt   = S_RSTART;
        end else begin
          res_nxt   = item_r.pointer;
          state_nxt = S_FINISH;
        end
      end
      S_AMOVE: begin
        if (!alloc_ok_r) begin
          st_nxt    = ST_OOM;
          state_nxt = S_FINISH;
        end else begin
          copy_nxt    = 16'({bsz2_r, 3'b000} - 17'd8);
          blk_nxt     = b_r;
          bsz_nxt     = bsz2_r;
          rel_ret_nxt = REL_FINISH;
          state_nxt   = S_RSTART;
        end
      end
      S_ASTART: begin
        prev_nxt    = NIL;
        prev_sz_nxt = '0;
        cur_nxt     = head_r;
        state_nxt   = S_AWALK;
      end
      S_AWALK: begin
        mem_g = cur_r[13:0];
        if (cur_r == NIL) begin
          amt_nxt     = {2'b00, rg_r - prev_sz_r};
          ext_rsz_nxt = 1'b0;
          state_nxt   = S_ESTART;
        end else begin
          state_nxt = S_ACHECK;
        end
      end
      S_ACHECK: begin
        if (mem_q.size >= rg_r) begin
          cur_sz_nxt = mem_q.size;
          link_nxt   = mem_q.next;
          if ((mem_q.size - rg_r) >= MIN_G) begin
            mem_we     = 1'b1;
            mem_g      = cur_r[13:0] + rg_r;
            mem_wd     = '{kind: K_FREE, size: mem_q.size - rg_r, next: mem_q.next};
            link_nxt   = {1'b0, cur_r[13:0] + rg_r};
            cur_sz_nxt = rg_r;
          end
          state_nxt = S_ATAKE;
        end else begin
          prev_nxt    = cur_r;
          prev_sz_nxt = mem_q.size;
          cur_nxt     = mem_q.next;
          state_nxt   = S_AWALK;
        end
      end
      S_ATAKE: begin
        mem_we    = 1'b1;
        mem_g     = cur_r[13:0];
        mem_wd    = '{kind: K_USED, size: cur_sz_r, next: NIL};
        state_nxt = S_ALINK;
      end
      S_ALINK: begin
        if (prev_r == NIL) begin
          head_nxt = link_r;
        end else begin
          mem_we = 1'b1;
          mem_g  = prev_r[13:0];
          mem_wd = '{kind: K_FREE, size: prev_sz_r, next: link_r};
        end
        res_nxt      = 16'({cur_r[13:0] + 14'd1, 3'b000});
        alloc_ok_nxt = 1'b1;
        state_nxt    = S_ARET;
      end
      S_ARET: begin
        state_nxt = alloc_mv_r ? S_AMOVE : S_FINISH;
        if (!alloc_ok_r) begin
          st_nxt = ST_OOM;
        end
      end
      S_ESTART: begin
        acc_nxt = '0;
        if ({1'b0, amt_r, 3'b000} >= OOM_LIM) begin
          ext_ok_nxt = 1'b0;
          state_nxt  = S_ERET;
        end else begin
          state_nxt = S_ERNDA;
        end
      end
      S_ERNDA: begin
        if (acc_r >= amt_r) begin
          ra_nxt = acc_r;
          if (started_r) begin
            start_nxt   = {2'b00, heap_end_r};
            new_end_nxt = {2'b00, heap_end_r} + acc_r;
            state_nxt   = S_ECHK;
          end else begin
            start_nxt = {2'b00, base_g};
            acc_nxt   = '0;
            state_nxt = S_ERNDS;
          end
        end else begin
          acc_nxt = acc_r + EXT_G;
        end
      end
      S_ERNDS: begin
        // first extension pads the start up to an extension boundary
        if (acc_r >= start_r) begin
          new_end_nxt = acc_r + ra_r;
          state_nxt   = S_ECHK;
        end else begin
          acc_nxt = acc_r + EXT_G;
        end
      end
      S_ECHK: begin
        if (new_end_r > {3'b000, ceil_r[15:3]} || new_end_r > NGRAN_W) begin
          ext_ok_nxt = 1'b0;
          state_nxt  = S_ERET;
        end else begin
          started_nxt  = 1'b1;
          heap_end_nxt = new_end_r[13:0];
          blk_nxt      = start_r[13:0];
          bsz_nxt      = 14'(new_end_r - start_r);
          rel_ret_nxt  = REL_EXT;
          state_nxt    = S_RSTART;
        end
      end
      S_ERET: begin
        mem_g = after_r;
        if (ext_rsz_r) begin
          if (ext_ok_r) begin
            state_nxt = S_ZREREAD;
          end else begin
            st_nxt    = ST_OOM;
            state_nxt = S_FINISH;
          end
        end else if (ext_ok_r) begin
          state_nxt = S_ASTART;
        end else begin
          alloc_ok_nxt = 1'b0;
          state_nxt    = S_ARET;
        end
      end
      S_RSTART: begin
        prev_nxt  = NIL;
        cur_nxt   = head_r;
        state_nxt = S_RWALK;
      end
      S_RWALK: begin
        mem_g = cur_r[13:0];
        if (cur_r != NIL && cur_r <= {1'b0, blk_r}) begin
          state_nxt = S_RSTEP;
        end else begin
          state_nxt = S_RMERGE;
        end
      end
      S_RSTEP: begin
        prev_nxt    = cur_r;
        prev_sz_nxt = mem_q.size;
        cur_nxt     = mem_q.next;
        state_nxt   = S_RWALK;
      end
      S_RMERGE: begin
        cur_sz_nxt = mem_q.size;
        cur_nx_nxt = mem_q.next;
        bnext_nxt  = cur_r;
        if (prev_r != NIL &&
            ({1'b0, prev_r[13:0]} + {1'b0, prev_sz_r}) == {1'b0, blk_r}) begin
          mem_we  = 1'b1;
          mem_g   = blk_r;
          mem_wd  = '{kind: K_NONE, size: '0, next: NIL};
          blk_nxt = prev_r[13:0];
          bsz_nxt = prev_sz_r + bsz_r;
        end else if (prev_r == NIL) begin
          head_nxt = {1'b0, blk_r};
        end else begin
          mem_we = 1'b1;
          mem_g  = prev_r[13:0];
          mem_wd = '{kind: K_FREE, size: prev_sz_r, next: {1'b0, blk_r}};
        end
        state_nxt = S_RNEXT;
      end
      S_RNEXT: begin
        if (cur_r != NIL && ({1'b0, blk_r} + {1'b0, bsz_r}) == cur_r) begin
          mem_we    = 1'b1;
          mem_g     = cur_r[13:0];
          mem_wd    = '{kind: K_NONE, size: '0, next: NIL};
          bnext_nxt = cur_nx_r;
          bsz_nxt   = bsz_r + cur_sz_r;
        end
        state_nxt = S_RFIN;
      end
      S_RFIN: begin
        mem_we = 1'b1;
        mem_g  = blk_r;
        mem_wd = '{kind: K_FREE, size: bsz_r, next: bnext_r};
        unique case (rel_ret_r)
          REL_ZOK: begin
            res_nxt   = item_r.pointer;
            state_nxt = S_FINISH;
          end
          REL_EXT: begin
            ext_ok_nxt = 1'b1;
            state_nxt  = S_ERET;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{result_pointer: (st_r == ST_OK) ? res_r : 16'd0,
                            status: st_r,
                            copy_bytes: (st_r == ST_OK) ? copy_r : 16'd0,
                            usable_bytes: usable_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // headers beyond the heap array are never stored
    if ({2'b00, mem_g} >= NGRAN_W) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      heap_end_r  <= '0;
      started_r   <= 1'b0;
      base_r      <= 16'd0;
      ceil_r      <= 16'd64512;
      out_valid_r <= 1'b0;
      ext_rsz_r   <= 1'b0;
      alloc_mv_r  <= 1'b0;
      ext_ok_r    <= 1'b0;
      alloc_ok_r  <= 1'b0;
      rel_ret_r   <= REL_FINISH;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      heap_end_r  <= heap_end_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      ext_rsz_r   <= ext_rsz_nxt;
      alloc_mv_r  <= alloc_mv_nxt;
      ext_ok_r    <= ext_ok_nxt;
      alloc_ok_r  <= alloc_ok_nxt;
      rel_ret_r   <= rel_ret_nxt;
      if (cfg_we) begin
        if (cfg_index) begin
          ceil_r <= cfg_data;
        end else begin
          base_r <= cfg_data;
        end
      end
    end
    item_r     <= item_nxt;
    rg_r       <= rg_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    cur_nx_r   <= cur_nx_nxt;
    link_r     <= link_nxt;
    bnext_r    <= bnext_nxt;
    prev_sz_r  <= prev_sz_nxt;
    cur_sz_r   <= cur_sz_nxt;
    blk_r      <= blk_nxt;
    bsz_r      <= bsz_nxt;
    b_r        <= b_nxt;
    bsz2_r     <= bsz2_nxt;
    after_r    <= after_nxt;
    asz_r      <= asz_nxt;
    ak_r       <= ak_nxt;
    amt_r      <= amt_nxt;
    acc_r      <= acc_nxt;
    ra_r       <= ra_nxt;
    start_r    <= start_nxt;
    new_end_r  <= new_end_nxt;
    res_r      <= res_nxt;
    copy_r     <= copy_nxt;
    usable_r   <= usable_nxt;
    st_r       <= st_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

### verif/ffha_checker.sv
// result checker for the first-fit heap allocator: keeps its own heap image,
// predicts each result item and compares it with what comes out; needs ffha_pkg
`timescale 1ns / 1ps

module ffha_checker
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int          GRANS    = 8192;
  localparam int unsigned NO_LINK  = 32'h20000;
  localparam int unsigned MIN_BLK  = 16;
  localparam int unsigned EXT_STEP = 1024;
  localparam int unsigned HEAP_MAX = 65536;

  logic [1:0]  heap_kind [GRANS];
  int unsigned heap_size [GRANS];
  int unsigned heap_link [GRANS];
  int unsigned list_head, heap_top, base_reg, ceil_reg;
  bit          started;
  out_item_t   expected_q[$];

  function automatic logic [1:0] kind_at(int unsigned a);
    return (a / 8 < GRANS) ? heap_kind[a / 8] : K_NONE;
  endfunction

  function automatic int unsigned size_at(int unsigned a);
    return (a / 8 < GRANS) ? heap_size[a / 8] : 0;
  endfunction

  function automatic int unsigned link_at(int unsigned a);
    return (a / 8 < GRANS) ? heap_link[a / 8] : NO_LINK;
  endfunction

  function automatic void hput(int unsigned a, logic [1:0] k, int unsigned s, int unsigned n);
    if (a / 8 < GRANS) begin
      heap_kind[a / 8] = k;
      heap_size[a / 8] = s;
      heap_link[a / 8] = n;
    end
  endfunction

  function automatic void set_size(int unsigned a, int unsigned s);
    if (a / 8 < GRANS) heap_size[a / 8] = s;
  endfunction

  function automatic void set_link(int unsigned a, int unsigned n);
    if (a / 8 < GRANS) heap_link[a / 8] = n;
  endfunction

  function automatic void relink(int unsigned prv, int unsigned lnk);
    if (prv == NO_LINK) list_head = lnk;
    else set_link(prv, lnk);
  endfunction

  function automatic int unsigned block_bytes(int unsigned req);
    int unsigned r;
    r = ((req + 15) / 8) * 8;
    return (r < MIN_BLK) ? MIN_BLK : r;
  endfunction

  // insert in address order and merge with touching neighbors
  function automatic void give_back(int unsigned blk);
    int unsigned prv, cur, steps;
    prv = NO_LINK;
    cur = list_head;
    steps = 0;
    while (cur != NO_LINK && steps < GRANS && cur <= blk) begin
      prv = cur;
      cur = link_at(cur);
      steps++;
    end
    if (prv != NO_LINK && prv + size_at(prv) == blk) begin
      set_size(prv, size_at(prv) + size_at(blk));
      hput(blk, K_NONE, 0, NO_LINK);
      blk = prv;
    end else begin
      relink(prv, blk);
      hput(blk, K_FREE, size_at(blk), cur);
    end
    if (cur != NO_LINK && blk + size_at(blk) == cur) begin
      set_link(blk, link_at(cur));
      set_size(blk, size_at(blk) + size_at(cur));
      hput(cur, K_NONE, 0, NO_LINK);
    end
  endfunction

  function automatic bit grow_heap(int unsigned amount);
    int unsigned start, new_end;
    if (amount >= 32'hFFFF - EXT_STEP) return 0;
    amount = ((amount + EXT_STEP - 1) / EXT_STEP) * EXT_STEP;
    if (started) begin
      start = heap_top;
    end else begin
      start = ((base_reg + 7) / 8) * 8;
      // first extension pads the heap start to a 1 KB boundary
      if (start % EXT_STEP != 0) amount += EXT_STEP - start % EXT_STEP;
    end
    new_end = start + amount;
    if (new_end > ceil_reg || new_end > HEAP_MAX) return 0;
    started = 1;
    heap_top = new_end;
    hput(start, K_USED, amount, NO_LINK);
    give_back(start);
    return 1;
  endfunction

  function automatic logic [1:0] first_fit(int unsigned req, output int unsigned ptr);
    int unsigned r, prv, cur, steps, sz, nx, lnk, need;
    r = block_bytes(req);
    ptr = 0;
    while (1'b1) begin
      prv = NO_LINK;
      cur = list_head;
      steps = 0;
      while (cur != NO_LINK && steps < GRANS) begin
        sz = size_at(cur);
        nx = link_at(cur);
        if (sz >= r) begin
          lnk = nx;
          if (sz - r >= MIN_BLK) begin
            hput(cur + r, K_FREE, sz - r, nx);
            lnk = cur + r;
            sz = r;
          end
          hput(cur, K_USED, sz, NO_LINK);
          relink(prv, lnk);
          ptr = cur + 8;
          return ST_OK;
        end
        prv = cur;
        cur = nx;
        steps++;
      end
      need = r - ((prv != NO_LINK) ? size_at(prv) : 0);
      if (!grow_heap(need)) return ST_OOM;
    end
    return ST_OOM;
  endfunction

  function automatic bit owned_block(int unsigned ptr, output int unsigned b);
    b = 0;
    if (ptr < 8) return 0;
    b = ptr - 8;
    if (b % 8 != 0) return 0;
    if (!started || b >= heap_top) return 0;
    return kind_at(b) == K_USED;
  endfunction

  function automatic logic [1:0] resize_block(int unsigned ptr, int unsigned req,
                                              output int unsigned res, output int unsigned copy);
    int unsigned b, r, sz, need, after, prv, cur, steps;
    logic [1:0] ak, st;
    res = 0;
    copy = 0;
    if (ptr == 0) return first_fit(req, res);
    if (!owned_block(ptr, b)) return ST_BAD;
    r = block_bytes(req);
    sz = size_at(b);
    if (sz < r) begin
      need = r - sz;
      after = b + sz;
      ak = (after < heap_top) ? kind_at(after) : K_NONE;
      // block or its free follower ends the heap: extend first
      if (after == heap_top || (ak == K_FREE && size_at(after) < need &&
                                after + size_at(after) == heap_top)) begin
        if (!grow_heap(b + r - heap_top)) return ST_OOM;
        ak = kind_at(after);
      end
      if (ak == K_FREE && size_at(after) >= need) begin
        prv = NO_LINK;
        cur = list_head;
        steps = 0;
        while (cur != NO_LINK && cur != after && steps < GRANS) begin
          prv = cur;
          cur = link_at(cur);
          steps++;
        end
        if (cur == after) relink(prv, link_at(after));
        sz += size_at(after);
        hput(after, K_NONE, 0, NO_LINK);
        set_size(b, sz);
      end else begin
        st = first_fit(req, res);
        if (st != ST_OK) return st;
        copy = sz - 8;
        give_back(b);
        return ST_OK;
      end
    end
    if (sz - r >= MIN_BLK) begin
      set_size(b, r);
      hput(b + r, K_USED, sz - r, NO_LINK);
      give_back(b + r);
    end
    res = ptr;
    return ST_OK;
  endfunction

  function automatic out_item_t heap_answer(in_item_t it);
    out_item_t   o;
    int unsigned res, copy, usable, b;
    logic [1:0]  st;
    res = 0;
    copy = 0;
    usable = 0;
    st = ST_OK;
    case (it.op)
      OP_ALLOC: begin
        st = first_fit(it.request_size, res);
      end
      OP_FREE: begin
        if (it.pointer != 0) begin
          if (owned_block(it.pointer, b)) give_back(b);
          else st = ST_BAD;
        end
      end
      OP_RESIZE: begin
        st = resize_block(it.pointer, it.request_size, res, copy);
      end
      default: begin
        if (it.pointer != 0) begin
          if (owned_block(it.pointer, b)) usable = size_at(b) - 8;
          else st = ST_BAD;
        end
      end
    endcase
    if (st != ST_OK) begin
      res = 0;
      copy = 0;
    end
    o.result_pointer = res[15:0];
    o.status = st;
    o.copy_bytes = copy[15:0];
    o.usable_bytes = usable[15:0];
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < GRANS; i++) hput(i * 8, K_NONE, 0, NO_LINK);
      list_head = NO_LINK;
      heap_top = 0;
      started = 0;
      base_reg = 0;
      ceil_reg = 64512;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) base_reg = cfg_data;
        else ceil_reg = cfg_data;
      end
      if (in_valid && !in_stall) expected_q.push_back(heap_answer(in_item));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.result_pointer !== want.result_pointer) begin
            $error("result_pointer expected %0d got %0d", want.result_pointer,
                   out_item.result_pointer);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.copy_bytes !== want.copy_bytes) begin
            $error("copy_bytes expected %0d got %0d", want.copy_bytes, out_item.copy_bytes);
            fail_count++;
          end
          if (out_item.usable_bytes !== want.usable_bytes) begin
            $error("usable_bytes expected %0d got %0d", want.usable_bytes,
                   out_item.usable_bytes);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### verif/tb_first_fit_heap_allocator.sv
// testbench top for the first-fit heap allocator: clock, reset, stimulus and verdict
// depends on ffha_pkg, first_fit_heap_allocator and ffha_checker
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_CEIL = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending;

  int          sent = 0, got = 0;
  bit          calm = 0, big_hold = 0;
  logic [15:0] ptr_pool[$];
  logic [15:0] last_res = '0;

  always #5 clk = ~clk;

  first_fit_heap_allocator uut (.*);

  ffha_checker chk (.*);

  // the last 200 nonzero pointers handed out: each header has been written at least once
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got <= got + 1;
      last_res <= out_item.result_pointer;
      if (out_item.result_pointer != 0) begin
        ptr_pool.push_back(out_item.result_pointer);
        if (ptr_pool.size() > 200) void'(ptr_pool.pop_front());
      end
    end
  end

  // result side
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = calm ? 0 : $urandom_range(0, 19);
      if (big_hold) begin
        w = 400;
        big_hold = 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic issue(op_t op, logic [15:0] req, logic [15:0] ptr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{op: op, request_size: req, pointer: ptr};
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (got != sent) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic issue_wait(op_t op, logic [15:0] req, logic [15:0] ptr,
                            output logic [15:0] res);
    issue(op, req, ptr);
    drain();
    res = last_res;
  endtask

  task automatic cfg_write(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_ptr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 78 && ptr_pool.size() > 0)
      return ptr_pool[$urandom_range(0, ptr_pool.size() - 1)];
    if (sel < 84) return 16'd0;
    if (sel < 88) return 16'($urandom_range(1, 7));
    // misaligned pointers and addresses whose block lies at or above the default ceiling of 64512
    if (sel < 94 && ptr_pool.size() > 0)
      return ptr_pool[$urandom_range(0, ptr_pool.size() - 1)] ^ 16'($urandom_range(1, 7));
    return 16'($urandom_range(16'hFC08, 16'hFFFF));
  endfunction

  function automatic logic [15:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 16'($urandom_range(0, 300));
    if (sel < 95) return 16'($urandom_range(301, 4000));
    return 16'($urandom());
  endfunction

  task automatic run_random(int n, int hold_at);
    int sel;
    op_t op;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == hold_at) big_hold = 1;
      sel = $urandom_range(0, 99);
      if (sel < 36) op = OP_ALLOC;
      else if (sel < 68) op = OP_FREE;
      else if (sel < 85) op = OP_RESIZE;
      else op = OP_QUERY;
      issue(op, pick_size(), pick_ptr());
    end
    calm = 0;
  endtask

  initial begin
    logic [15:0] a, b, c, d;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unaligned base that also needs padding to a 1 KB boundary
    cfg_write(REG_BASE, 16'h1234);
    cfg_write(REG_CEIL, 16'hFFFF);
    issue(OP_FREE, 0, 0);
    issue(OP_QUERY, 0, 0);
    issue(OP_QUERY, 0, 16'hFFF8);
    issue_wait(OP_ALLOC, 0, 0, a);
    issue(OP_ALLOC, 16'hFFFF, 0);
    issue_wait(OP_ALLOC, 100, 0, b);
    issue_wait(OP_ALLOC, 24, 0, c);
    issue_wait(OP_ALLOC, 1000, 0, d);
    issue(OP_QUERY, 0, a);
    issue(OP_QUERY, 0, b + 16'd1);
    issue(OP_FREE, 0, 16'd5);
    issue(OP_RESIZE, 20, b);
    issue(OP_RESIZE, 500, b);
    issue_wait(OP_RESIZE, 3000, c, c);
    issue(OP_FREE, 0, a);
    issue(OP_FREE, 0, a);
    issue(OP_RESIZE, 16'hFFFF, d);
    issue(OP_RESIZE, 10, 0);
    issue(OP_QUERY, 0, c);
    issue(OP_FREE, 0, d);
    issue(OP_QUERY, 0, d);
    issue(OP_ALLOC, 16'hFFFF, 0);
    issue(OP_RESIZE, 40000, c);
    drain();

    run_random(500, 200);
    drain();

    // no room to extend at all
    cfg_write(REG_CEIL, 16'h0000);
    run_random(200, -1);
    drain();

    // base has no effect any more, small ceiling
    cfg_write(REG_BASE, 16'hFFFF);
    cfg_write(REG_CEIL, 16'd16384);
    run_random(400, -1);
    drain();

    cfg_write(REG_CEIL, 16'd64512);
    run_random(250, 100);
    drain();
    run_random(250, -1);
    drain();
    repeat (50) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/ffha_pkg.sv
hdl/first_fit_heap_allocator.sv
verif/ffha_checker.sv
verif/tb_first_fit_heap_allocator.sv
